FILE: sv/dso_pkg.sv
// ----------------------------------------------------------------------------
// dso_pkg: shared types and constants of the detuned saw oscillator bank
// Holds the voice tables, the register reset values and the microcode ROM.
// ----------------------------------------------------------------------------
package dso_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned BaseWidth  = 23;
  localparam int unsigned ScaleWidth = 16;
  localparam int unsigned SampleWidth = 24;
  localparam int unsigned MagWidth   = 13;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned AddrWidth  = 3;

  localparam logic [BaseWidth-1:0]  BaseReset  = 23'd78643;
  localparam logic [ScaleWidth-1:0] ScaleReset = 16'd6400;

  localparam logic [AddrWidth-1:0] AddrBase  = 3'd0;
  localparam logic [AddrWidth-1:0] AddrScale = 3'd4;

  // Voice weights in unsigned Q0.16.
  localparam logic [WeightWidth-1:0] Weight [TableDepth] = '{
    16'd8192, 16'd4915, 16'd6554, 16'd13107, 16'd13107, 16'd6554, 16'd4915,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // Detune offsets in Q0.16, kept as magnitude and sign.
  localparam logic [MagWidth-1:0] DetMag [TableDepth] = '{
    13'd7210, 13'd4121, 13'd1279, 13'd0, 13'd1305, 13'd4074, 13'd7042,
    13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0
  };
  localparam logic [TableDepth-1:0] DetNeg = 16'b0000_0000_0000_0111;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_BS,
    STEP_MW,
    STEP_AD,
    STEP_UP,
    STEP_OUT
  } step_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_BS,
    MUL_WT,
    MUL_DT
  } mul_sel_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_LOOP,
    COND_WAIT_OUT
  } cond_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     in_rdy;
    logic     ld_bs;
    logic     ld_prod;
    logic     acc_add;
    logic     phase_upd;
    logic     out_ld;
    cond_e    cond;
    step_e    target;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic last_voice;
    logic out_free;
  } status_t;

  function automatic cw_t rom(step_e s);
    cw_t cw;
    cw = '{mul_sel: MUL_NONE, in_rdy: 1'b0, ld_bs: 1'b0, ld_prod: 1'b0,
           acc_add: 1'b0, phase_upd: 1'b0, out_ld: 1'b0, cond: COND_NEXT,
           target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        cw.in_rdy = 1'b1;
        cw.cond   = COND_WAIT_IN;
      end
      STEP_BS: begin
        cw.mul_sel = MUL_BS;
        cw.ld_bs   = 1'b1;
      end
      STEP_MW: begin
        cw.mul_sel = MUL_WT;
        cw.ld_prod = 1'b1;
      end
      STEP_AD: begin
        cw.mul_sel = MUL_DT;
        cw.ld_prod = 1'b1;
        cw.acc_add = 1'b1;
      end
      STEP_UP: begin
        cw.phase_upd = 1'b1;
        cw.cond      = COND_LOOP;
        cw.target    = STEP_MW;
      end
      STEP_OUT: begin
        cw.out_ld = 1'b1;
        cw.cond   = COND_WAIT_OUT;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.cond   = COND_NEXT;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: sv/dso_if.sv
// ----------------------------------------------------------------------------
// dso_if: stream channels of the detuned saw oscillator bank
// Valid/ready channels for the tick input and the sample output.
// ----------------------------------------------------------------------------
interface dso_in_if;
  logic valid;
  logic ready;
  logic resync;

  modport source (output valid, output resync, input ready);
  modport sink (input valid, input resync, output ready);
endinterface

interface dso_out_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

FILE: sv/detuned_saw_oscillator_bank_top.sv
// ----------------------------------------------------------------------------
// detuned_saw_oscillator_bank_top: bank of detuned sawtooth oscillators
// After a tick is accepted the program runs a base-times-scale step and then,
// per voice, three program steps (MW, AD, UP) on one shared multiplier before
// the sample is loaded; no new tick is taken until the sample is in the output
// register. Reset clears all phases, sets the registers to their defaults and
// returns the sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module detuned_saw_oscillator_bank_top #(
  parameter int unsigned NUM_VOICES_IN_BANK = 7,
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dso_in_if.sink                        in_ch,
  dso_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dso_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dso_pkg::*;

  logic [BaseWidth-1:0]  base;
  logic [ScaleWidth-1:0] scale;
  cw_t                   cw;
  status_t               status;

  dso_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base_o  (base),
    .scale_o (scale)
  );

  dso_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cw_o     (cw)
  );

  dso_dp #(
    .NUM_VOICES_IN_BANK (NUM_VOICES_IN_BANK),
    .PHASE_BITS         (PHASE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cw_i         (cw),
    .base_i       (base),
    .scale_i      (scale),
    .in_valid_i   (in_ch.valid),
    .in_resync_i  (in_ch.resync),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_sample_o (out_ch.sample),
    .status_o     (status)
  );

  assign in_ch.ready = cw.in_rdy;

endmodule

FILE: sv/dso_cfg.sv
// ----------------------------------------------------------------------------
// dso_cfg: configuration registers
// APB-style write and read of the base increment and the detune scale.
// ----------------------------------------------------------------------------
module dso_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dso_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [dso_pkg::BaseWidth-1:0]    base_o,
  output logic [dso_pkg::ScaleWidth-1:0]   scale_o
);
  import dso_pkg::*;

  logic [BaseWidth-1:0]  base_q;
  logic [ScaleWidth-1:0] scale_q;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      scale_q <= ScaleReset;
    end else if (wr_en) begin
      if (paddr[2] == AddrScale[2]) begin
        scale_q <= pwdata[ScaleWidth-1:0];
      end else begin
        base_q <= pwdata[BaseWidth-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == AddrScale[2]) begin
      prdata = {{(32-ScaleWidth){1'b0}}, scale_q};
    end else begin
      prdata = {{(32-BaseWidth){1'b0}}, base_q};
    end
  end

  assign base_o  = base_q;
  assign scale_o = scale_q;

endmodule

FILE: sv/dso_seq.sv
// ----------------------------------------------------------------------------
// dso_seq: microcode sequencer
// Step counter over the control ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module dso_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dso_pkg::status_t status_i,
  output dso_pkg::cw_t     cw_o
);
  import dso_pkg::*;

  step_e step_q;
  step_e step_d;
  cw_t   cw;
  logic  accept;

  assign cw     = rom(step_q);
  assign cw_o   = cw;
  assign accept = cw.in_rdy & status_i.in_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    step_d = step_q;
    case (cw.cond)
      COND_NEXT: begin
        step_d = step_e'(3'(step_q) + 3'd1);
      end
      COND_WAIT_IN: begin
        if (status_i.in_valid) begin
          step_d = step_e'(3'(step_q) + 3'd1);
        end
      end
      COND_LOOP: begin
        if (status_i.last_voice) begin
          step_d = step_e'(3'(step_q) + 3'd1);
        end else begin
          step_d = cw.target;
        end
      end
      COND_WAIT_OUT: begin
        if (status_i.out_free) begin
          step_d = cw.target;
        end
      end
      default: begin
        step_d = STEP_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> step_q == STEP_BS)
    else $error("Accepted transaction did not start the program.");

  a_loop_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_UP && !status_i.last_voice) |=> step_q == STEP_MW)
    else $error("Voice loop did not jump back.");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.out_ld && status_i.out_free) |=> step_q == STEP_IDLE)
    else $error("Program did not return to idle after the result.");

endmodule

FILE: sv/dso_dp.sv
// ----------------------------------------------------------------------------
// dso_dp: oscillator datapath
// Phase store, shared multiplier, accumulator and output register.
// ----------------------------------------------------------------------------
module dso_dp #(
  parameter int unsigned NUM_VOICES_IN_BANK = 7,
  parameter int unsigned PHASE_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dso_pkg::cw_t                   cw_i,
  input  logic [dso_pkg::BaseWidth-1:0]  base_i,
  input  logic [dso_pkg::ScaleWidth-1:0] scale_i,
  input  logic                           in_valid_i,
  input  logic                           in_resync_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [23:0]             out_sample_o,
  output dso_pkg::status_t               status_o
);
  import dso_pkg::*;

  localparam int unsigned VW = (NUM_VOICES_IN_BANK > 1) ? $clog2(NUM_VOICES_IN_BANK) : 1;
  localparam logic [VW-1:0] LastVoice = VW'(NUM_VOICES_IN_BANK - 1);

  logic [PHASE_BITS-1:0]        phase_q [NUM_VOICES_IN_BANK];
  logic [VW-1:0]                voice_q;
  logic [BaseWidth+ScaleWidth-1:0] bs_q;
  logic [52:0]                  prod_q;
  logic signed [47:0]           acc_q;
  logic                         out_valid_q;
  logic signed [23:0]           sample_q;

  logic                         accept;
  logic                         out_free;
  logic                         last_voice;
  logic [3:0]                   tix;
  logic [PHASE_BITS-1:0]        ph;
  logic [PHASE_BITS+23:0]       ph_sh;
  logic signed [23:0]           q23;
  logic signed [39:0]           mul_a;
  logic signed [16:0]           mul_b;
  logic signed [56:0]           mul_p;
  logic [52:0]                  rnd_sum;
  logic [23:0]                  delta;
  logic [23:0]                  inc24;
  logic [PHASE_BITS+23:0]       inc_sh;
  logic [PHASE_BITS-1:0]        inc_s;
  logic signed [47:0]           acc_rnd;

  assign accept     = cw_i.in_rdy & in_valid_i;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_voice = voice_q == LastVoice;
  assign tix        = 4'(voice_q);

  assign ph    = phase_q[voice_q];
  assign ph_sh = {ph, 24'd0} >> PHASE_BITS;
  assign q23   = ph_sh[23:0];

  always_comb begin
    case (cw_i.mul_sel)
      MUL_BS: begin
        mul_a = {17'd0, base_i};
        mul_b = {1'b0, scale_i};
      end
      MUL_WT: begin
        mul_a = {{16{q23[23]}}, q23};
        mul_b = {1'b0, Weight[tix]};
      end
      MUL_DT: begin
        mul_a = {1'b0, bs_q};
        mul_b = {4'd0, DetMag[tix]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rnd_sum = prod_q + 53'h0_0000_8000_0000;
  assign delta   = {3'd0, rnd_sum[52:32]};
  assign inc24   = DetNeg[tix] ? ({1'b0, base_i} - delta) : ({1'b0, base_i} + delta);
  assign inc_sh  = {inc24, {PHASE_BITS{1'b0}}} >> 24;
  assign inc_s   = inc_sh[PHASE_BITS-1:0];

  assign acc_rnd = acc_q + 48'sh8000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VOICES_IN_BANK; i++) begin
        phase_q[i] <= '0;
      end
      voice_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        voice_q <= '0;
        if (in_resync_i) begin
          for (int i = 0; i < NUM_VOICES_IN_BANK; i++) begin
            phase_q[i] <= '0;
          end
        end
      end else if (cw_i.phase_upd) begin
        phase_q[voice_q] <= ph + inc_s;
        voice_q          <= last_voice ? '0 : voice_q + VW'(1);
      end
      if (cw_i.out_ld && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.ld_bs) begin
      bs_q <= mul_p[BaseWidth+ScaleWidth-1:0];
    end
    if (cw_i.ld_prod) begin
      prod_q <= mul_p[52:0];
    end
    if (accept) begin
      acc_q <= '0;
    end else if (cw_i.acc_add) begin
      acc_q <= acc_q + {{7{prod_q[40]}}, prod_q[40:0]};
    end
    if (cw_i.out_ld && out_free) begin
      sample_q <= acc_rnd[39:16];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = sample_q;
  assign status_o     = '{in_valid: in_valid_i, last_voice: last_voice, out_free: out_free};

  a_out_from_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cw_i.out_ld))
    else $error("Output transaction appeared without a load step.");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> acc_q == 48'sd0)
    else $error("Accumulator not cleared at the start of a tick.");

  a_resync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_resync_i) |=> phase_q[0] == '0)
    else $error("Resync did not clear the phases.");

endmodule
